### src/lrbb_pkg.sv
// Package for the link to register bus bridge.
// Holds job types, opcodes and result kind codes shared by all modules.
// No dependencies.
package lrbb_pkg;

  localparam logic [7:0] OpPing = 8'h00;
  localparam logic [7:0] OpReg  = 8'h01;

  localparam int FlagWriteBit = 7;
  localparam int FlagIncrBit  = 6;

  localparam logic [1:0] KindReply = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;

  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  typedef enum logic [1:0] {
    JobEcho,
    JobWrite,
    JobHeader,
    JobData
  } jkind_e;

  typedef struct packed {
    jkind_e      kind;
    logic        last;   // echo: reply end
    logic        req;    // header/data: issue a read request after the bytes
    logic [7:0]  aux;    // echo byte or flag byte
    logic [15:0] len;
    logic [15:0] cnt;
    logic [31:0] addr;   // write address or read request address
    logic [31:0] data;   // write word, read word or base address
  } job_t;

endpackage

### src/lrbb_front.sv
// Front end of the bridge: parses link bytes and read data into jobs.
// Depends on lrbb_pkg.
module lrbb_front #(
  parameter int MAX_READ_WORDS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           command_i,
  input  logic [7:0]     link_byte_i,
  input  logic           chunk_end_i,
  input  logic [31:0]    read_data_i,
  output logic           job_valid_o,
  output lrbb_pkg::job_t job_o
);

  localparam logic [15:0] MaxWords = 16'(MAX_READ_WORDS);

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  flag_q, flag_d;
  logic [31:0] base_q, base_d;
  logic [31:0] cur_q, cur_d;
  logic [23:0] asm_q, asm_d;
  logic [1:0]  biw_q, biw_d;
  logic [13:0] wr_cnt_q, wr_cnt_d;
  logic [15:0] rcount_q, rcount_d;
  logic [15:0] left_q, left_d;
  logic        pend_q, pend_d;

  logic [7:0]  op;
  logic        is_write;
  logic [15:0] len_m5;
  logic [13:0] total;
  logic [15:0] cnt;
  logic [31:0] cur_inc;

  assign is_write = flag_q[lrbb_pkg::FlagWriteBit];
  assign op       = (pos_q == 4'd0) ? link_byte_i : opcode_q;
  assign len_m5   = len_q - 16'd5;
  assign total    = (len_q > 16'd5) ? len_m5[15:2] : 14'd0;
  assign cnt      = (rcount_d > MaxWords) ? MaxWords : rcount_d;
  assign cur_inc  = flag_q[lrbb_pkg::FlagIncrBit] ? cur_q + 32'd4 : cur_q;

  always_comb begin
    pos_d       = pos_q;
    opcode_d    = opcode_q;
    len_d       = len_q;
    flag_d      = flag_q;
    base_d      = base_q;
    cur_d       = cur_q;
    asm_d       = asm_q;
    biw_d       = biw_q;
    wr_cnt_d    = wr_cnt_q;
    rcount_d    = rcount_q;
    left_d      = left_q;
    pend_d      = pend_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept_i && command_i && pend_q) begin
      left_d      = left_q - 16'd1;
      job_valid_o = 1'b1;
      job_o.kind  = lrbb_pkg::JobData;
      job_o.data  = read_data_i;
      job_o.addr  = cur_q;
      job_o.req   = (left_d != 16'd0);
      if (left_d != 16'd0) begin
        cur_d = cur_inc;
      end else begin
        pend_d = 1'b0;
      end
    end else if (accept_i && !command_i && !pend_q) begin
      if (pos_q == 4'd0) begin
        opcode_d = link_byte_i;
      end
      if (op == lrbb_pkg::OpPing) begin
        job_valid_o = 1'b1;
        job_o.kind  = lrbb_pkg::JobEcho;
        job_o.aux   = link_byte_i;
        job_o.last  = chunk_end_i;
      end else if (op == lrbb_pkg::OpReg && pos_q != 4'd0) begin
        case (pos_q)
          4'd1: len_d = {link_byte_i, 8'h00};
          4'd2: len_d = len_q | {8'h00, link_byte_i};
          4'd3: flag_d = link_byte_i;
          4'd4, 4'd5, 4'd6: base_d = {base_q[23:0], link_byte_i};
          4'd7: begin
            base_d   = {base_q[23:0], link_byte_i};
            cur_d    = {base_q[23:0], link_byte_i};
            asm_d    = '0;
            biw_d    = '0;
            wr_cnt_d = '0;
            rcount_d = '0;
          end
          default: begin
            if (is_write) begin
              if (biw_q != 2'd3) begin
                asm_d = {asm_q[15:0], link_byte_i};
                biw_d = biw_q + 2'd1;
              end else begin
                biw_d = 2'd0;
                if (wr_cnt_q < total) begin
                  job_valid_o = 1'b1;
                  job_o.kind  = lrbb_pkg::JobWrite;
                  job_o.addr  = cur_q;
                  job_o.data  = {asm_q, link_byte_i};
                  wr_cnt_d    = wr_cnt_q + 14'd1;
                  cur_d       = cur_inc;
                end
              end
            end else if (pos_q <= 4'd9) begin
              rcount_d = {rcount_q[7:0], link_byte_i};
            end
          end
        endcase
        if (chunk_end_i && !is_write && pos_q >= 4'd9) begin
          job_valid_o = 1'b1;
          job_o.kind  = lrbb_pkg::JobHeader;
          job_o.aux   = flag_q;
          job_o.len   = {cnt[13:0], 2'b00} + 16'd7;
          job_o.cnt   = cnt;
          job_o.data  = base_q;
          job_o.addr  = cur_q;
          job_o.req   = (cnt != 16'd0);
          if (cnt != 16'd0) begin
            cur_d  = cur_inc;
            left_d = cnt;
            pend_d = 1'b1;
          end
        end
      end
      if (chunk_end_i) begin
        pos_d = 4'd0;
        biw_d = 2'd0;
      end else if (pos_q < 4'd10) begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      opcode_q <= '0;
      len_q    <= '0;
      flag_q   <= '0;
      base_q   <= '0;
      cur_q    <= '0;
      asm_q    <= '0;
      biw_q    <= '0;
      wr_cnt_q <= '0;
      rcount_q <= '0;
      left_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      opcode_q <= opcode_d;
      len_q    <= len_d;
      flag_q   <= flag_d;
      base_q   <= base_d;
      cur_q    <= cur_d;
      asm_q    <= asm_d;
      biw_q    <= biw_d;
      wr_cnt_q <= wr_cnt_d;
      rcount_q <= rcount_d;
      left_q   <= left_d;
      pend_q   <= pend_d;
    end
  end

endmodule

### src/lrbb_queue.sv
// Job queue between the parser and the result sequencer.
// Depends on lrbb_pkg.
module lrbb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lrbb_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lrbb_pkg::job_t head_o
);

  lrbb_pkg::job_t mem_q [lrbb_pkg::QDepth];

  logic [lrbb_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [lrbb_pkg::QPtrW:0]   count_q, count_d;
  logic                       do_push, do_pop;

  assign full_o  = (count_q == (lrbb_pkg::QPtrW+1)'(lrbb_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (lrbb_pkg::QPtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (lrbb_pkg::QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + (lrbb_pkg::QPtrW)'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + (lrbb_pkg::QPtrW)'(1);
      end
    end
  end

endmodule

### src/lrbb_back.sv
// Back end of the bridge: expands each queued job into result transfers.
// Depends on lrbb_pkg.
module lrbb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  lrbb_pkg::job_t job_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     reply_byte_o,
  output logic           reply_end_o,
  output logic [31:0]    bus_address_o,
  output logic [31:0]    bus_data_o,
  output logic           step_last_o
);

  logic [3:0] idx_q, idx_d;
  logic [3:0] n_items;
  logic       xfer;

  always_comb begin
    case (job_i.kind)
      lrbb_pkg::JobHeader: n_items = job_i.req ? 4'd11 : 4'd10;
      lrbb_pkg::JobData:   n_items = job_i.req ? 4'd5 : 4'd4;
      default:             n_items = 4'd1;
    endcase
  end

  assign valid_o     = !empty_i;
  assign step_last_o = (idx_q == n_items - 4'd1);
  assign xfer        = valid_o && ready_i;
  assign pop_o       = xfer && step_last_o;

  always_comb begin
    kind_o        = lrbb_pkg::KindReply;
    reply_byte_o  = '0;
    reply_end_o   = 1'b0;
    bus_address_o = '0;
    bus_data_o    = '0;
    case (job_i.kind)
      lrbb_pkg::JobEcho: begin
        reply_byte_o = job_i.aux;
        reply_end_o  = job_i.last;
      end
      lrbb_pkg::JobWrite: begin
        kind_o        = lrbb_pkg::KindWrite;
        bus_address_o = job_i.addr;
        bus_data_o    = job_i.data;
      end
      lrbb_pkg::JobHeader: begin
        case (idx_q)
          4'd0: reply_byte_o = lrbb_pkg::OpReg;
          4'd1: reply_byte_o = job_i.len[15:8];
          4'd2: reply_byte_o = job_i.len[7:0];
          4'd3: reply_byte_o = job_i.aux;
          4'd4: reply_byte_o = job_i.data[31:24];
          4'd5: reply_byte_o = job_i.data[23:16];
          4'd6: reply_byte_o = job_i.data[15:8];
          4'd7: reply_byte_o = job_i.data[7:0];
          4'd8: reply_byte_o = job_i.cnt[15:8];
          4'd9: begin
            reply_byte_o = job_i.cnt[7:0];
            reply_end_o  = !job_i.req;
          end
          default: begin
            kind_o        = lrbb_pkg::KindRead;
            bus_address_o = job_i.addr;
          end
        endcase
      end
      default: begin
        case (idx_q)
          4'd0: reply_byte_o = job_i.data[31:24];
          4'd1: reply_byte_o = job_i.data[23:16];
          4'd2: reply_byte_o = job_i.data[15:8];
          4'd3: begin
            reply_byte_o = job_i.data[7:0];
            reply_end_o  = !job_i.req;
          end
          default: begin
            kind_o        = lrbb_pkg::KindRead;
            bus_address_o = job_i.addr;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = 4'd0;
    end else if (xfer) begin
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> idx_q < n_items)
    else $error("sequencer index beyond job length");

  a_end_is_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && reply_end_o) |-> kind_o == lrbb_pkg::KindReply)
    else $error("reply end on a bus transfer");

  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 4'd0)
    else $error("index not cleared after last transfer of a job");

endmodule

### src/link_to_register_bus_bridge.sv
// Link to register bus bridge, top level.
// Depends on lrbb_pkg, lrbb_front, lrbb_queue and lrbb_back.
//
// Link bytes and returned bus read words enter on the slave stream; the
// parser takes one transfer per cycle whenever its four-entry job queue has
// room, and each transfer adds at most one job. The sequencer behind the
// queue sends one result transfer per cycle while the master stream is
// ready: one per echo byte or bus write, 10 per read reply header (11 with
// its first read request) and 4 per returned read word (5 with the next
// request). Input thus sustains one transfer per cycle for ping and write
// chunks and is set by the output sequencer during read replies.
module link_to_register_bus_bridge #(
  parameter int MAX_READ_WORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // link_byte[7:0], read_data[39:8]
  input  logic        s_axis_tuser_i,  // command
  input  logic        s_axis_tlast_i,  // chunk_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,  // reply_byte[7:0], bus_address[39:8],
                                       // bus_data[71:40], step_last[72], zero
  output logic [1:0]  m_axis_tuser_o,  // kind
  output logic        m_axis_tlast_o   // reply_end
);

  lrbb_pkg::job_t push_job, head_job;
  logic           push, full, empty, pop, accept;
  logic [7:0]     reply_byte;
  logic [31:0]    bus_address, bus_data;
  logic           step_last;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  lrbb_front #(
    .MAX_READ_WORDS(MAX_READ_WORDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (s_axis_tuser_i),
    .link_byte_i (s_axis_tdata_i[7:0]),
    .chunk_end_i (s_axis_tlast_i),
    .read_data_i (s_axis_tdata_i[39:8]),
    .job_valid_o (push),
    .job_o       (push_job)
  );

  lrbb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  lrbb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .job_i         (head_job),
    .pop_o         (pop),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .kind_o        (m_axis_tuser_o),
    .reply_byte_o  (reply_byte),
    .reply_end_o   (m_axis_tlast_o),
    .bus_address_o (bus_address),
    .bus_data_o    (bus_data),
    .step_last_o   (step_last)
  );

  assign m_axis_tdata_o = {7'd0, step_last, bus_data, bus_address, reply_byte};

endmodule
